/* hw/rtl/vector_clock_text_parser_assert.svh */
// Assertion shorthands used by the checker file.
`ifndef VECTOR_CLOCK_TEXT_PARSER_ASSERT_SVH
`define VECTOR_CLOCK_TEXT_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define VCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/vct_pkg.sv */
`timescale 1ns / 1ps

package vct_pkg;

    localparam int REPLICAS      = 32;
    localparam int POSITION_BITS = 16;

    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 5;
    localparam int COUNT_W  = 63;
    localparam int STATUS_W = 3;
    localparam int ERRPOS_W = 16;
    localparam int SIG_W    = 64;
    localparam int PMAP_W   = 32;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // input tdata layout
    localparam int IN_OP_LSB   = 0;
    localparam int IN_CHAR_LSB = IN_OP_LSB + OP_W;
    localparam int IN_IDX_LSB  = IN_CHAR_LSB + CHAR_W;
    localparam int IN_VAL_LSB  = IN_IDX_LSB + IDX_W;
    localparam int IN_BITS     = IN_VAL_LSB + COUNT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_ERRPOS_LSB = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_PREV_LSB   = OUT_ERRPOS_LSB + ERRPOS_W;
    localparam int OUT_SIG_LSB    = OUT_PREV_LSB + COUNT_W;
    localparam int OUT_PMAP_LSB   = OUT_SIG_LSB + SIG_W;
    localparam int OUT_BITS       = OUT_PMAP_LSB + PMAP_W;
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

    typedef enum logic [OP_W-1:0] {
        OP_PARSE  = 2'd0,
        OP_FOLLOW = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_PARSING         = 3'd0,
        ST_ACCEPTED        = 3'd1,
        ST_PARSE_ERROR     = 3'd2,
        ST_FOLLOW_DONE     = 3'd3,
        ST_FOLLOW_REJECTED = 3'd4,
        ST_CLEARED         = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PH_BEGIN  = 3'd0,
        PH_KEY    = 3'd1,
        PH_KEYNUM = 3'd2,
        PH_SEP    = 3'd3,
        PH_VAL    = 3'd4,
        PH_VALNUM = 3'd5,
        PH_COMMA  = 3'd6,
        PH_END    = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        PR_BUSY   = 2'd0,
        PR_ACCEPT = 2'd1,
        PR_ERROR  = 2'd2
    } t_presult;

    typedef struct packed {
        t_presult              result;
        logic                  accept;
        logic [ERRPOS_W-1:0]   err_pos;
        logic                  entry_valid;
        logic [IDX_W-1:0]      entry_replica;
        logic [COUNT_W-1:0]    entry_value;
    } t_parse_out;

    typedef struct packed {
        logic                  follow_ok;
        logic [COUNT_W-1:0]    prev_count;
        logic [SIG_W-1:0]      signature;
        logic [PMAP_W-1:0]     presence;
    } t_clock_view;

endpackage

/* hw/rtl/vct_parser.sv */
`timescale 1ns / 1ps

module vct_parser import vct_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_op                 i_op,
    input  logic [CHAR_W-1:0]   i_char,
    input  logic [REPLICAS-1:0] i_nonzero,
    output t_parse_out          o_parse
);

    localparam int ACC_EXT_W = COUNT_W + 4;

    t_phase                   r_phase, n_phase;
    logic [COUNT_W-1:0]       r_acc, n_acc;
    logic                     r_ovf, n_ovf;
    logic [IDX_W-1:0]         r_held, n_held;
    logic [POSITION_BITS-1:0] r_pos, n_pos;

    logic                     w_digit, w_blank, w_space;
    logic [3:0]               w_dval;
    logic [ACC_EXT_W-1:0]     w_prod;
    logic                     w_acc_ovf;
    logic                     w_key_ok, w_val_ok;
    logic [POSITION_BITS-1:0] w_pos_inc;
    logic                     w_num_step, w_num_bad, w_entry_wr;
    t_phase                   w_eff, w_go;
    t_presult                 w_result;

    assign w_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_blank = (i_char == CH_SPACE) || (i_char == CH_TAB);
    assign w_space = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign w_dval  = 4'(i_char - CH_ZERO);

    // acc * 10 + digit, wide enough to see a carry past bit 62
    assign w_prod    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + ACC_EXT_W'(w_dval);
    assign w_acc_ovf = |w_prod[ACC_EXT_W-1:COUNT_W];

    assign w_key_ok  = !r_ovf && (r_acc < COUNT_W'(REPLICAS));
    assign w_val_ok  = !r_ovf && !i_nonzero[r_held];
    assign w_pos_inc = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;

    // a terminated number hands its character on to the following phase
    always_comb begin
        w_num_step = 1'b0;
        w_num_bad  = 1'b0;
        w_entry_wr = 1'b0;
        w_eff      = r_phase;
        if (r_phase == PH_KEYNUM) begin
            w_num_step = w_digit;
            w_num_bad  = !w_digit && !w_key_ok;
            w_eff      = PH_SEP;
        end else if (r_phase == PH_VALNUM) begin
            w_num_step = w_digit;
            w_num_bad  = !w_digit && !w_val_ok;
            w_entry_wr = !w_digit && w_val_ok;
            w_eff      = PH_COMMA;
        end
    end

    // next state
    always_comb begin
        w_go     = w_eff;
        w_result = PR_BUSY;
        if (w_num_step) begin
            w_go = r_phase;
        end else if (w_num_bad) begin
            w_result = PR_ERROR;
        end else begin
            unique case (w_eff)
                PH_BEGIN: begin
                    if (i_char == CH_LBRACE) w_go = PH_KEY;
                    else if (!w_blank) w_result = PR_ERROR;
                end
                PH_KEY: begin
                    if (w_digit) w_go = PH_KEYNUM;
                    else if (i_char == CH_RBRACE) w_go = PH_END;
                    else if (!w_blank) w_result = PR_ERROR;
                end
                PH_SEP: begin
                    if (i_char == CH_COLON) w_go = PH_VAL;
                    else if (!w_blank) w_result = PR_ERROR;
                end
                PH_VAL: begin
                    if (w_digit) w_go = PH_VALNUM;
                    else if (!w_blank) w_result = PR_ERROR;
                end
                PH_COMMA: begin
                    if (i_char == CH_RBRACE) w_go = PH_END;
                    else if (i_char == CH_COMMA) w_go = PH_KEY;
                    else if (!w_space) w_result = PR_ERROR;
                end
                PH_END: begin
                    if (i_char == CH_NUL) w_result = PR_ACCEPT;
                    else if (!w_blank) w_result = PR_ERROR;
                end
                default: w_result = PR_ERROR;
            endcase
        end

        unique case (i_op)
            OP_PARSE: n_phase = (w_result != PR_BUSY) ? PH_BEGIN : w_go;
            OP_CLEAR: n_phase = PH_BEGIN;
            default:  n_phase = r_phase;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_acc  = r_acc;
        n_ovf  = r_ovf;
        n_held = r_held;
        n_pos  = r_pos;
        if (i_op == OP_PARSE) begin
            n_pos = w_pos_inc;
            if (w_num_step) begin
                if (w_acc_ovf) n_ovf = 1'b1;
                else n_acc = w_prod[COUNT_W-1:0];
            end else if ((w_go == PH_KEYNUM) || (w_go == PH_VALNUM)) begin
                n_acc = COUNT_W'(w_dval);
                n_ovf = 1'b0;
            end
            if ((r_phase == PH_KEYNUM) && !w_digit && w_key_ok) begin
                n_held = r_acc[IDX_W-1:0];
            end
            if (w_result != PR_BUSY) begin
                n_acc  = '0;
                n_ovf  = 1'b0;
                n_held = '0;
                n_pos  = '0;
            end
        end else if (i_op == OP_CLEAR) begin
            n_acc  = '0;
            n_ovf  = 1'b0;
            n_held = '0;
            n_pos  = '0;
        end

        o_parse.result        = w_result;
        o_parse.accept        = (i_op == OP_PARSE) && (w_result == PR_ACCEPT);
        o_parse.err_pos       = ((i_op == OP_PARSE) && (w_result == PR_ERROR)) ?
                                ERRPOS_W'(w_pos_inc) : '0;
        o_parse.entry_valid   = (i_op == OP_PARSE) && w_entry_wr;
        o_parse.entry_replica = r_held;
        o_parse.entry_value   = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BEGIN;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_held  <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_held  <= n_held;
            r_pos   <= n_pos;
        end
    end

endmodule

/* hw/rtl/vct_clock_store.sv */
`timescale 1ns / 1ps

module vct_clock_store import vct_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_op                 i_op,
    input  t_parse_out          i_parse,
    input  logic [IDX_W-1:0]    i_idx,
    input  logic [COUNT_W-1:0]  i_val,
    output logic [REPLICAS-1:0] o_nonzero,
    output t_clock_view         o_view
);

    // an entry whose presence bit is clear reads as zero
    logic [COUNT_W-1:0]  r_table [REPLICAS];
    logic [REPLICAS-1:0] r_presence, n_presence;
    logic [REPLICAS-1:0] r_nonzero, n_nonzero;
    logic [SIG_W-1:0]    r_sig, n_sig;
    logic [SIG_W-1:0]    r_pending, n_pending;

    logic [COUNT_W-1:0]  w_prev;
    logic                w_idx_ok, w_follow_ok;
    logic [SIG_W-1:0]    w_delta;
    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_addr;
    logic [COUNT_W-1:0]  w_wr_data;

    assign w_prev      = r_presence[i_idx] ? r_table[i_idx] : '0;
    assign w_idx_ok    = {1'b0, i_idx} < (IDX_W + 1)'(REPLICAS);
    assign w_follow_ok = (i_op == OP_FOLLOW) && w_idx_ok && (i_val > w_prev);
    assign w_delta     = {1'b0, i_val} - {1'b0, w_prev};

    always_comb begin
        n_presence = r_presence;
        n_nonzero  = r_nonzero;
        n_sig      = r_sig;
        n_pending  = r_pending;
        w_wr_en    = 1'b0;
        w_wr_addr  = i_idx;
        w_wr_data  = i_val;
        case (i_op)
            OP_FOLLOW: begin
                if (w_follow_ok) begin
                    n_presence[i_idx] = 1'b1;
                    n_nonzero[i_idx]  = 1'b1;
                    n_sig             = r_sig + w_delta;
                    n_pending         = r_pending + w_delta;
                    w_wr_en           = 1'b1;
                end
            end
            OP_PARSE: begin
                // a parsed entry only lands on a zero counter, so the delta is the value
                if (i_parse.entry_valid) begin
                    n_presence[i_parse.entry_replica] = 1'b1;
                    n_nonzero[i_parse.entry_replica]  = |i_parse.entry_value;
                    n_pending = r_pending + {1'b0, i_parse.entry_value};
                    w_wr_en   = 1'b1;
                    w_wr_addr = i_parse.entry_replica;
                    w_wr_data = i_parse.entry_value;
                end
                if (i_parse.accept) begin
                    n_sig = r_pending;
                end
            end
            OP_CLEAR: begin
                n_presence = '0;
                n_nonzero  = '0;
                n_sig      = '0;
                n_pending  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presence <= '0;
            r_nonzero  <= '0;
            r_sig      <= '0;
            r_pending  <= '0;
        end else begin
            r_presence <= n_presence;
            r_nonzero  <= n_nonzero;
            r_sig      <= n_sig;
            r_pending  <= n_pending;
        end
    end

    assign o_nonzero         = r_nonzero;
    assign o_view.follow_ok  = w_follow_ok;
    assign o_view.prev_count = w_idx_ok ? w_prev : '0;
    assign o_view.signature  = n_sig;
    assign o_view.presence   = PMAP_W'(n_presence);

endmodule

/* hw/rtl/vector_clock_text_parser.sv */
`timescale 1ns / 1ps
// Path: an input transaction is captured in the input register, then passes once through the
// parser and counter table into the result register when the output can take it.
// Throughput: one item per cycle unless stalled; parser phase and counter table update jointly.
// Reset: synchronous, active low; clears the clock, the parser and both stage valids.
// No clearing pass: the presence bits mask the counter table.

module vector_clock_text_parser import vct_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // operation, char_code, replica_index, new_count
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status, error_position, previous_count, clock_signature, presence_map
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                   r_in_valid;
    t_op                    r_op;
    logic [CHAR_W-1:0]      r_char;
    logic [IDX_W-1:0]       r_idx;
    logic [COUNT_W-1:0]     r_val;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic                   w_fire;
    t_op                    w_op;
    t_parse_out             w_parse;
    t_clock_view            w_view;
    logic [REPLICAS-1:0]    w_nonzero;
    t_status                w_status;
    logic [ERRPOS_W-1:0]    w_errpos;
    logic [COUNT_W-1:0]     w_prev;

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    // stalled cycles present a no-op to the state
    assign w_op          = w_fire ? r_op : OP_NONE;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op   <= t_op'(s_axis_tdata[IN_OP_LSB +: OP_W]);
            r_char <= s_axis_tdata[IN_CHAR_LSB +: CHAR_W];
            r_idx  <= s_axis_tdata[IN_IDX_LSB +: IDX_W];
            r_val  <= s_axis_tdata[IN_VAL_LSB +: COUNT_W];
        end
    end

    vct_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_op),
        .i_char    (r_char),
        .i_nonzero (w_nonzero),
        .o_parse   (w_parse)
    );

    vct_clock_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_op),
        .i_parse   (w_parse),
        .i_idx     (r_idx),
        .i_val     (r_val),
        .o_nonzero (w_nonzero),
        .o_view    (w_view)
    );

    always_comb begin
        w_status = ST_PARSING;
        w_errpos = '0;
        w_prev   = '0;
        case (r_op)
            OP_PARSE: begin
                case (w_parse.result)
                    PR_ACCEPT: w_status = ST_ACCEPTED;
                    PR_ERROR:  w_status = ST_PARSE_ERROR;
                    default:   w_status = ST_PARSING;
                endcase
                w_errpos = w_parse.err_pos;
            end
            OP_FOLLOW: begin
                w_status = w_view.follow_ok ? ST_FOLLOW_DONE : ST_FOLLOW_REJECTED;
                w_prev   = w_view.prev_count;
            end
            OP_CLEAR: w_status = ST_CLEARED;
            default:  w_status = ST_PARSING;
        endcase

        n_out_data = '0;
        n_out_data[OUT_STATUS_LSB +: STATUS_W] = w_status;
        n_out_data[OUT_ERRPOS_LSB +: ERRPOS_W] = w_errpos;
        n_out_data[OUT_PREV_LSB +: COUNT_W]    = w_prev;
        n_out_data[OUT_SIG_LSB +: SIG_W]       = w_view.signature;
        n_out_data[OUT_PMAP_LSB +: PMAP_W]     = w_view.presence;
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* hw/rtl/vct_checker.sv */
`timescale 1ns / 1ps
`include "vector_clock_text_parser_assert.svh"

module vct_checker import vct_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata
);

    logic [STATUS_W-1:0] w_status;
    logic [ERRPOS_W-1:0] w_errpos;
    logic [COUNT_W-1:0]  w_prev;
    logic [SIG_W-1:0]    w_sig;
    logic [PMAP_W-1:0]   w_pmap;

    assign w_status = i_m_tdata[OUT_STATUS_LSB +: STATUS_W];
    assign w_errpos = i_m_tdata[OUT_ERRPOS_LSB +: ERRPOS_W];
    assign w_prev   = i_m_tdata[OUT_PREV_LSB +: COUNT_W];
    assign w_sig    = i_m_tdata[OUT_SIG_LSB +: SIG_W];
    assign w_pmap   = i_m_tdata[OUT_PMAP_LSB +: PMAP_W];

    `VCT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata), "result changed while stalled")
    `VCT_ASSERT_IMP(a_errpos_only_on_error, i_clk, i_rst_n, i_m_tvalid && (w_status != ST_PARSE_ERROR), w_errpos == '0, "error position outside a parse error")
    `VCT_ASSERT_IMP(a_error_has_pos, i_clk, i_rst_n, i_m_tvalid && (w_status == ST_PARSE_ERROR), w_errpos != '0, "parse error without a position")
    `VCT_ASSERT_IMP(a_prev_only_on_follow, i_clk, i_rst_n, i_m_tvalid && (w_status != ST_FOLLOW_DONE) && (w_status != ST_FOLLOW_REJECTED), w_prev == '0, "previous count outside a follow")
    `VCT_ASSERT_IMP(a_clear_empties, i_clk, i_rst_n, i_m_tvalid && (w_status == ST_CLEARED), (w_sig == '0) && (w_pmap == '0), "clock not empty after clear")

endmodule

bind vector_clock_text_parser vct_checker u_vct_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
